[hw/rtl/cld_pkg.sv]
// Shared types, constants and position helpers for the console line discipline.
`timescale 1ns / 1ps

package cld_pkg;

  localparam int RING_DEPTH = 128;
  localparam int POS_SPAN   = 2 * RING_DEPTH;
  localparam int POS_W      = $clog2(POS_SPAN);
  localparam int IDX_W      = $clog2(RING_DEPTH);
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [POS_W:0]   posw_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  localparam logic [7:0] KEY_NUL  = 8'h00;
  localparam logic [7:0] KEY_INTR = 8'h03;
  localparam logic [7:0] KEY_EOF  = 8'h04;
  localparam logic [7:0] KEY_LF   = 8'h0A;
  localparam logic [7:0] KEY_CR   = 8'h0D;
  localparam logic [7:0] KEY_KILL = 8'h15;
  localparam logic [7:0] KEY_DEL  = 8'h7F;

  localparam logic [2:0] KIND_ECHO  = 3'd0;
  localparam logic [2:0] KIND_ERASE = 3'd1;
  localparam logic [2:0] KIND_DATA  = 3'd2;
  localparam logic [2:0] KIND_EMPTY = 3'd3;
  localparam logic [2:0] KIND_EOF   = 3'd4;
  localparam logic [2:0] KIND_INTR  = 3'd5;

  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef struct packed {
    logic       operation;
    logic [7:0] char_in;
    logic       first_of_read;
  } cld_in_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data_byte;
    logic [7:0] erase_count;
    logic       line_ready;
    logic       line_end;
  } cld_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_KILL_SCAN,
    ST_READ_CHK,
    ST_EMIT
  } cld_state_t;

  function automatic pos_t pos_inc(input pos_t p);
    pos_inc = (p == pos_t'(POS_SPAN - 1)) ? '0 : pos_t'(p + pos_t'(1));
  endfunction

  function automatic pos_t pos_dec(input pos_t p);
    pos_dec = (p == '0) ? pos_t'(POS_SPAN - 1) : pos_t'(p - pos_t'(1));
  endfunction

  function automatic idx_t pos_idx(input pos_t p);
    posw_t w;
    w = {1'b0, p};
    if (w >= posw_t'(RING_DEPTH)) w = w - posw_t'(RING_DEPTH);
    pos_idx = idx_t'(w);
  endfunction

  function automatic pos_t pos_dist(input pos_t hi, input pos_t lo);
    posw_t w;
    w = {1'b0, hi} + posw_t'(POS_SPAN) - {1'b0, lo};
    if (w >= posw_t'(POS_SPAN)) w = w - posw_t'(POS_SPAN);
    pos_dist = pos_t'(w);
  endfunction

  function automatic pos_t pos_add_depth(input pos_t p);
    posw_t w;
    w = {1'b0, p} + posw_t'(RING_DEPTH);
    if (w >= posw_t'(POS_SPAN)) w = w - posw_t'(POS_SPAN);
    pos_add_depth = pos_t'(w);
  endfunction

  function automatic logic [7:0] sat_count(input cnt_t c);
    logic [CNT_W+7:0] w;
    w = {8'b0, c};
    sat_count = (w > (CNT_W + 8)'(255)) ? 8'hFF : w[7:0];
  endfunction

endpackage

[hw/rtl/cld_line_store.sv]
// Line ring storage: one write port, one read port with registered data.
`timescale 1ns / 1ps

module cld_line_store (
  input  logic             clk,
  input  logic             wr_en,
  input  cld_pkg::idx_t    wr_idx,
  input  logic [7:0]       wr_data,
  input  cld_pkg::idx_t    rd_idx,
  output logic [7:0]       rd_data
);
  import cld_pkg::*;

  logic [7:0] mem [RING_DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_idx];
  end

  assign rd_data = rd_data_r;

endmodule

[hw/rtl/console_line_discipline.sv]
// Console line discipline top level: canonical line editing over a byte ring.
//
//   channel  direction  handshake           word
//   in_      input      in_valid/in_ready   cld_in_t  (key byte or read request)
//   out_     output     out_valid/out_ready cld_out_t (echo/erase/data/empty/eof/intr)
//
// One word at a time. Key store, interrupt and delete go from decode to emit;
// a read request goes through the read check to emit, or straight to emit when
// nothing is committed; kill-line erases up to RING_DEPTH - 1 bytes, stopping
// at a newline, by a one-byte-per-cycle backward scan of the ring's single read
// port, then emits. A word that gives no result returns the block to idle.
// A stalled output holds the sequencer in its emit state. Reset empties the
// ring by clearing the three positions; ring contents need no clearing.
`timescale 1ns / 1ps

module console_line_discipline (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cld_pkg::cld_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output cld_pkg::cld_out_t out_data
);
  import cld_pkg::*;

  cld_state_t state_r, state_nxt;
  cld_in_t    item_r, item_nxt;
  pos_t       read_pos_r, read_pos_nxt;
  pos_t       commit_pos_r, commit_pos_nxt;
  pos_t       edit_pos_r, edit_pos_nxt;
  cnt_t       cnt_r, cnt_nxt;
  cld_out_t   res_r, res_nxt;
  cld_out_t   out_data_r, out_data_nxt;
  logic       out_valid_r, out_valid_nxt;

  logic       wr_en;
  idx_t       wr_idx;
  logic [7:0] wr_data;
  idx_t       rd_idx;
  logic [7:0] rd_data;

  logic       in_fire, out_free;
  logic       read_empty, edit_clean, has_room;
  logic [7:0] ch_eff;
  pos_t       edit_inc, edit_dec;
  cnt_t       cnt_inc;

  cld_line_store u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_idx  (wr_idx),
    .wr_data (wr_data),
    .rd_idx  (rd_idx),
    .rd_data (rd_data)
  );

  assign in_ready   = (state_r == ST_IDLE);
  assign in_fire    = in_valid & in_ready;
  assign out_free   = ~out_valid_r | out_ready;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  assign read_empty = (read_pos_r == commit_pos_r);
  assign edit_clean = (edit_pos_r == commit_pos_r);
  assign has_room   = ({1'b0, pos_dist(edit_pos_r, read_pos_r)} < posw_t'(RING_DEPTH));
  assign ch_eff     = (item_r.char_in == KEY_CR) ? KEY_LF : item_r.char_in;
  assign edit_inc   = pos_inc(edit_pos_r);
  assign edit_dec   = pos_dec(edit_pos_r);
  assign cnt_inc    = cnt_t'(cnt_r + cnt_t'(1));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        if (item_r.operation == OP_READ) begin
          state_nxt = read_empty ? ST_EMIT : ST_READ_CHK;
        end else begin
          priority if (item_r.char_in == KEY_INTR) begin
            state_nxt = ST_EMIT;
          end else if (item_r.char_in == KEY_KILL) begin
            state_nxt = edit_clean ? ST_IDLE : ST_KILL_SCAN;
          end else if (item_r.char_in == KEY_DEL) begin
            state_nxt = edit_clean ? ST_IDLE : ST_EMIT;
          end else if (item_r.char_in != KEY_NUL && has_room) begin
            state_nxt = ST_EMIT;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_KILL_SCAN: begin
        if (rd_data == KEY_LF) begin
          state_nxt = (cnt_r == '0) ? ST_IDLE : ST_EMIT;
        end else if (edit_dec == commit_pos_r) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_READ_CHK: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    item_nxt       = item_r;
    read_pos_nxt   = read_pos_r;
    commit_pos_nxt = commit_pos_r;
    edit_pos_nxt   = edit_pos_r;
    cnt_nxt        = cnt_r;
    res_nxt        = res_r;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r & ~out_ready;
    wr_en          = 1'b0;
    wr_idx         = pos_idx(edit_pos_r);
    wr_data        = ch_eff;
    rd_idx         = pos_idx(edit_dec);

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) item_nxt = in_data;
      end
      ST_DECODE: begin
        res_nxt = '0;
        cnt_nxt = '0;
        if (item_r.operation == OP_READ) begin
          rd_idx = pos_idx(read_pos_r);
          res_nxt.kind = KIND_EMPTY;
        end else begin
          priority if (item_r.char_in == KEY_INTR) begin
            res_nxt.kind = KIND_INTR;
          end else if (item_r.char_in == KEY_KILL) begin
            res_nxt.kind = KIND_ERASE;
          end else if (item_r.char_in == KEY_DEL) begin
            res_nxt.kind        = KIND_ERASE;
            res_nxt.erase_count = 8'd1;
            if (!edit_clean) edit_pos_nxt = edit_dec;
          end else if (item_r.char_in != KEY_NUL && has_room) begin
            wr_en             = 1'b1;
            edit_pos_nxt      = edit_inc;
            res_nxt.kind      = KIND_ECHO;
            res_nxt.data_byte = ch_eff;
            // commit on newline, end-of-file or a ring that just filled
            if (ch_eff == KEY_LF || ch_eff == KEY_EOF ||
                edit_inc == pos_add_depth(read_pos_r)) begin
              commit_pos_nxt     = edit_inc;
              res_nxt.line_ready = 1'b1;
            end
          end else begin
            res_nxt = '0;
          end
        end
      end
      ST_KILL_SCAN: begin
        // rd_data holds the byte just before edit_pos
        if (rd_data != KEY_LF) begin
          edit_pos_nxt        = edit_dec;
          cnt_nxt             = cnt_inc;
          res_nxt.erase_count = sat_count(cnt_inc);
          rd_idx              = pos_idx(pos_dec(edit_dec));
        end else begin
          res_nxt.erase_count = sat_count(cnt_r);
        end
      end
      ST_READ_CHK: begin
        if (rd_data == KEY_EOF) begin
          res_nxt.kind = KIND_EOF;
          if (item_r.first_of_read) read_pos_nxt = pos_inc(read_pos_r);
        end else begin
          res_nxt.kind      = KIND_DATA;
          res_nxt.data_byte = rd_data;
          res_nxt.line_end  = (rd_data == KEY_LF);
          read_pos_nxt      = pos_inc(read_pos_r);
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      read_pos_r   <= '0;
      commit_pos_r <= '0;
      edit_pos_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      read_pos_r   <= read_pos_nxt;
      commit_pos_r <= commit_pos_nxt;
      edit_pos_r   <= edit_pos_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    cnt_r      <= cnt_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
